FILE: rtl/ordered_list_store_with_deletion_top_defines.svh
// Assertion macros for the ordered list store.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef ORDERED_LIST_STORE_WITH_DELETION_TOP_DEFINES_SVH
`define ORDERED_LIST_STORE_WITH_DELETION_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OLSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define OLSD_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define OLSD_ASSERT(lbl, prop, msg)
`define OLSD_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: rtl/olsd_pkg.sv
// Shared constants and types for the ordered list store.
// No dependencies.
`default_nettype none
package olsd_pkg;
	localparam int OLSD_LIST_DEPTH = 64;
	localparam int OLSD_DATA_W = 32;

	localparam logic [2:0] CMD_APPEND   = 3'd0;
	localparam logic [2:0] CMD_DEL_HEAD = 3'd1;
	localparam logic [2:0] CMD_DEL_TAIL = 3'd2;
	localparam logic [2:0] CMD_DEL_VAL  = 3'd3;
	localparam logic [2:0] CMD_LIST     = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_LISTED    = 3'd4;

	// cell controls: load at tail, shift toward head, wrap head into tail
	typedef struct packed {
		logic load;
		logic shift;
		logic wrap;
	} olsd_cell_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/olsd_cell.sv
// One list slot: holds an element, loads at the tail, shifts toward the head.
// Depends on olsd_pkg.
`default_nettype none
module olsd_cell
	import olsd_pkg::*;
#(
	parameter int LIST_DEPTH = OLSD_LIST_DEPTH,
	parameter int IDX = 0,
	localparam int CW = $clog2(LIST_DEPTH + 1)
) (
	input  wire logic                   clk,
	input  wire olsd_cell_ctl_t         ctl,
	input  wire logic [CW-1:0]          cnt,
	input  wire logic [OLSD_DATA_W-1:0] head,
	input  wire logic [OLSD_DATA_W-1:0] din,
	input  wire logic [OLSD_DATA_W-1:0] nxt,
	output logic      [OLSD_DATA_W-1:0] data
);
	logic [OLSD_DATA_W-1:0] data_q;
	logic at_tail;
	logic at_end;

	assign at_tail = (cnt == CW'(IDX));
	assign at_end  = (cnt == CW'(IDX + 1));

	always_ff @(posedge clk) begin
		if (ctl.load && at_tail) begin
			data_q <= din;
		end else if (ctl.shift) begin
			data_q <= (ctl.wrap && at_end) ? head : nxt;
		end
	end

	assign data = data_q;
endmodule
`default_nettype wire

FILE: rtl/ordered_list_store_with_deletion_top.sv
// Ordered list store: command control plus a row of olsd_cell slots.
// Depends on olsd_pkg, olsd_cell and the assertion macro header.
//
// Usage: a command (command, value) is taken at a clock edge with start high
// and busy low. Each result appears on status/element/last for exactly one
// cycle with strobe high; the receiver cannot stall it.
// Append, delete head and delete tail, and any command on an empty list,
// give their single result the cycle after acceptance and keep busy low,
// so such commands run one per cycle.
// Delete by value and list rotate the whole list once through the slot row,
// one element per cycle, with busy high for the whole pass. A list emits one
// result per cycle, each registered from one step of the pass; delete by value
// reports once, after the last step of the pass.
// A new command is taken in the cycle its predecessor's last result shows.
// Unknown command codes are taken and give no result.
// Reset empties the list at once; slot contents are not cleared.
`default_nettype none
`include "ordered_list_store_with_deletion_top_defines.svh"
module ordered_list_store_with_deletion_top
	import olsd_pkg::*;
#(
	parameter int LIST_DEPTH = OLSD_LIST_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic        [2:0]             command,
	input  wire logic signed [OLSD_DATA_W-1:0] value,
	output logic                               strobe,
	output logic             [2:0]             status,
	output logic signed      [OLSD_DATA_W-1:0] element,
	output logic                               last
);
	localparam int CW = $clog2(LIST_DEPTH + 1);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t                 state_q;
	logic                   is_list_q;
	logic [OLSD_DATA_W-1:0] val_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          rem_q;
	logic                   found_q;
	logic                   strobe_q;
	logic [2:0]             status_q;
	logic [OLSD_DATA_W-1:0] element_q;
	logic                   last_q;

	olsd_cell_ctl_t         ctl;
	logic [OLSD_DATA_W-1:0] cell_data [LIST_DEPTH];
	logic [OLSD_DATA_W-1:0] head;
	logic                   run;
	logic                   take;
	logic                   is_empty;
	logic                   is_full;
	logic                   keep;

	assign run      = (state_q == S_RUN);
	assign busy     = run;
	assign take     = start && !run;
	assign head     = cell_data[0];
	assign is_empty = (cnt_q == '0);
	assign is_full  = (cnt_q == CW'(LIST_DEPTH));
	assign keep     = is_list_q || found_q || (head != val_q);

	always_comb begin
		ctl.load  = take && (command == CMD_APPEND) && !is_full;
		ctl.shift = run || (take && (command == CMD_DEL_HEAD) && !is_empty);
		ctl.wrap  = run && keep;
	end

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic [OLSD_DATA_W-1:0] nxt;
		if (i == LIST_DEPTH - 1) begin : g_end
			assign nxt = head;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end
		olsd_cell #(
			.LIST_DEPTH (LIST_DEPTH),
			.IDX        (i)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.cnt  (cnt_q),
			.head (head),
			.din  (value),
			.nxt  (nxt),
			.data (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			strobe_q  <= 1'b0;
			rem_q     <= '0;
			found_q   <= 1'b0;
			is_list_q <= 1'b0;
			status_q  <= ST_OK;
			element_q <= '0;
			last_q    <= 1'b0;
			val_q     <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q  <= ST_OK;
						element_q <= '0;
						last_q    <= 1'b1;
						val_q     <= value;
						is_list_q <= (command == CMD_LIST);
						found_q   <= 1'b0;
						rem_q     <= cnt_q;
						unique case (command)
							CMD_APPEND: begin
								strobe_q <= 1'b1;
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							CMD_DEL_HEAD, CMD_DEL_TAIL: begin
								strobe_q <= 1'b1;
								if (is_empty) begin
									status_q <= ST_EMPTY;
								end else begin
									cnt_q <= cnt_q - CW'(1);
								end
							end
							CMD_DEL_VAL, CMD_LIST: begin
								if (is_empty) begin
									strobe_q <= 1'b1;
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_RUN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RUN: begin
					rem_q <= rem_q - CW'(1);
					if (!keep) begin
						cnt_q   <= cnt_q - CW'(1);
						found_q <= 1'b1;
					end
					if (is_list_q) begin
						strobe_q  <= 1'b1;
						status_q  <= ST_LISTED;
						element_q <= head;
						last_q    <= (rem_q == CW'(1));
					end else if (rem_q == CW'(1)) begin
						strobe_q  <= 1'b1;
						status_q  <= (found_q || !keep) ? ST_OK : ST_NOT_FOUND;
						element_q <= '0;
						last_q    <= 1'b1;
					end
					if (rem_q == CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe  = strobe_q;
	assign status  = status_q;
	assign element = element_q;
	assign last    = last_q;

	`OLSD_ASSERT_NEVER(a_cnt_bound, cnt_q > CW'(LIST_DEPTH), "element count above depth")
	`OLSD_ASSERT_NEVER(a_run_rem, run && (rem_q == '0), "pass running with no steps left")
	`OLSD_ASSERT(a_single_last, strobe && (status != ST_LISTED) |-> last && (element == '0), "status result not final or carries data")
	`OLSD_ASSERT(a_drop_once, $rose(found_q) |-> (cnt_q + CW'(1) == $past(cnt_q)), "match removal did not shorten list")
	`OLSD_ASSERT(a_run_quiet_in, run && !is_list_q && (rem_q != CW'(1)) |=> !strobe, "delete by value reported early")
endmodule
`default_nettype wire
